// ===== design/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared definitions for the lasso polygon containment block
// Command codes, store sizes and the structs between the top level and the
// edge walker.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int MAX_VERTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int COORD_W   = 16;
    localparam int VERT_W    = 2 * COORD_W;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_POINT  = 2'd2,
        CMD_BOX    = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // Request to walk all edges for one query point.
    typedef struct packed {
        logic                      start;
        logic [CNT_W-1:0]          count;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_walk_req;

    // Walk finished, with the final crossing parity.
    typedef struct packed {
        logic done;
        logic odd;
    } t_walk_rsp;

    // Read port request toward the vertex store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

// ===== design/lasso_polygon_containment_top.sv =====
// ----------------------------------------------------------------------------
// lasso_polygon_containment_top: lasso polygon point and box containment
// Stores a closed polygon in a vertex RAM and answers containment queries
// with the even-odd crossing rule.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+------------------------------------
//  input   | i_valid / o_stall        | i_command, i_x_low, i_y_low,
//          |                          | i_x_high, i_y_high
//  output  | o_valid / i_stall        | o_inside_res, o_status
//
// Clear, append and tests on fewer than three vertices answer on the cycle
// after the item is accepted. A point test over n stored vertices makes n + 1
// reads of the single RAM read port to close the ring, then a three-stage
// compare pipeline drains. A box test walks once per corner and stops at the
// first corner found outside. Reset (synchronous, active low) clears the
// state, vertex count, result valid flag and corner; the input is stalled
// during a walk and while a held result is not taken.
module lasso_polygon_containment_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic signed [15:0] i_x_low,
    input  logic signed [15:0] i_y_low,
    input  logic signed [15:0] i_x_high,
    input  logic signed [15:0] i_y_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_inside_res,
    output logic        o_status
);

    // Control state.
    lpc_pkg::t_state           r_state, n_state;
    logic [lpc_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_corner, n_corner;

    // Payload registers.
    logic                      r_inside, n_inside;
    logic                      r_status, n_status;
    logic                      r_is_box, n_is_box;
    logic signed [15:0]        r_xl, n_xl;
    logic signed [15:0]        r_yl, n_yl;
    logic signed [15:0]        r_xh, n_xh;
    logic signed [15:0]        r_yh, n_yh;

    lpc_pkg::t_walk_req         walk_req;
    lpc_pkg::t_walk_rsp         walk_rsp;
    lpc_pkg::t_rd_req           rd_req;
    logic [lpc_pkg::VERT_W-1:0] rd_data;

    logic                       accept;
    logic                       out_take;
    logic                       out_load;
    logic                       wr_en;
    logic                       full;

    assign out_take = r_out_valid && !i_stall;
    assign full     = (r_count == lpc_pkg::CNT_W'(lpc_pkg::MAX_VERTS));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !out_take;
        n_corner    = r_corner;
        n_inside    = r_inside;
        n_status    = r_status;
        n_is_box    = r_is_box;
        n_xl        = r_xl;
        n_yl        = r_yl;
        n_xh        = r_xh;
        n_yh        = r_yh;
        out_load    = 1'b0;
        wr_en       = 1'b0;
        o_stall     = 1'b1;
        accept      = 1'b0;

        walk_req.start = 1'b0;
        walk_req.count = r_count;
        walk_req.px    = i_x_low;
        walk_req.py    = i_y_low;

        case (r_state)
            lpc_pkg::S_IDLE: begin
                // Take an item only when its result has somewhere to go.
                o_stall = r_out_valid && i_stall;
                accept  = i_valid && !o_stall;
                if (accept) begin
                    n_xl     = i_x_low;
                    n_yl     = i_y_low;
                    n_xh     = i_x_high;
                    n_yh     = i_y_high;
                    n_corner = 2'd0;
                    n_is_box = (lpc_pkg::t_cmd'(i_command) == lpc_pkg::CMD_BOX);
                    case (lpc_pkg::t_cmd'(i_command))
                        lpc_pkg::CMD_CLEAR: begin
                            n_count  = '0;
                            out_load = 1'b1;
                            n_inside = 1'b0;
                            n_status = 1'b0;
                        end
                        lpc_pkg::CMD_APPEND: begin
                            out_load = 1'b1;
                            n_inside = 1'b0;
                            n_status = full;
                            if (!full) begin
                                wr_en   = 1'b1;
                                n_count = r_count + lpc_pkg::CNT_W'(1);
                            end
                        end
                        lpc_pkg::CMD_POINT, lpc_pkg::CMD_BOX: begin
                            n_status = 1'b0;
                            if (r_count < lpc_pkg::CNT_W'(3)) begin
                                // Degenerate polygon: always outside.
                                out_load = 1'b1;
                                n_inside = 1'b0;
                            end else begin
                                walk_req.start = 1'b1;
                                n_state        = lpc_pkg::S_WALK;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            n_inside = 1'b0;
                            n_status = 1'b0;
                        end
                    endcase
                end
            end
            lpc_pkg::S_WALK: begin
                // Corner order: (xl,yl), (xl,yh), (xh,yh), (xh,yl).
                walk_req.px = n_corner[1] ? r_xh : r_xl;
                walk_req.py = (n_corner == 2'd1 || n_corner == 2'd2) ? r_yh : r_yl;
                if (walk_rsp.done) begin
                    if (r_is_box && walk_rsp.odd && r_corner != 2'd3) begin
                        n_corner       = r_corner + 2'd1;
                        walk_req.px    = n_corner[1] ? r_xh : r_xl;
                        walk_req.py    = (n_corner == 2'd1 || n_corner == 2'd2) ? r_yh : r_yl;
                        walk_req.start = 1'b1;
                    end else begin
                        out_load = 1'b1;
                        n_inside = walk_rsp.odd;
                        n_state  = lpc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lpc_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpc_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_corner    <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_corner    <= n_corner;
        end
        r_inside <= n_inside;
        r_status <= n_status;
        r_is_box <= n_is_box;
        r_xl     <= n_xl;
        r_yl     <= n_yl;
        r_xh     <= n_xh;
        r_yh     <= n_yh;
    end

    // Vertex store: x in the low half, y in the high half.
    lpc_ram #(
        .WIDTH (lpc_pkg::VERT_W),
        .DEPTH (lpc_pkg::MAX_VERTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[lpc_pkg::ADDR_W-1:0]),
        .i_wr_data ({i_y_low, i_x_low}),
        .i_rd_en   (rd_req.en),
        .i_rd_addr (rd_req.addr),
        .o_rd_data (rd_data)
    );

    lpc_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (walk_req),
        .o_rsp     (walk_rsp),
        .o_rd      (rd_req),
        .i_rd_data (rd_data)
    );

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_status     = r_status;

    // The store is never written beyond its depth.
    a_no_overflow_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !full)
        else $error("vertex written into a full store");

    // A new result never overwrites one that has not been taken.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten");

    // The walker only reports completion during a walk.
    a_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_rsp.done |-> (r_state == lpc_pkg::S_WALK))
        else $error("walker done outside of a walk");

    // A test that starts a walk leaves the block busy on the next cycle.
    a_walk_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && walk_req.start) |=> o_stall)
        else $error("input not stalled during a walk");

endmodule

// ===== design/lpc_ram.sv =====
// ----------------------------------------------------------------------------
// lpc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lpc_walker.sv =====
// ----------------------------------------------------------------------------
// lpc_walker: even-odd edge walker
// Streams the last vertex, then every stored vertex; forms each edge from the
// previous and current vertex, toggling a parity bit per crossing right of the point.
// ----------------------------------------------------------------------------
module lpc_walker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpc_pkg::t_walk_req          i_req,
    output lpc_pkg::t_walk_rsp          o_rsp,
    output lpc_pkg::t_rd_req            o_rd,
    input  logic [lpc_pkg::VERT_W-1:0]  i_rd_data
);

    localparam int DW = lpc_pkg::COORD_W + 1;
    localparam int PW = 2 * DW;

    // Control.
    logic                      r_busy,    n_busy;
    logic                      r_issuing, n_issuing;
    logic [lpc_pkg::CNT_W-1:0] r_idx,     n_idx;
    logic                      r_rd_vld,  n_rd_vld;
    logic                      r_first,   n_first;
    logic                      r_s2_vld,  n_s2_vld;
    logic                      r_s3_vld,  n_s3_vld;
    logic                      r_odd,     n_odd;

    // Payload.
    logic [lpc_pkg::CNT_W-1:0]          r_count, n_count;
    logic signed [lpc_pkg::COORD_W-1:0] r_px,    n_px;
    logic signed [lpc_pkg::COORD_W-1:0] r_py,    n_py;
    logic [lpc_pkg::VERT_W-1:0]         r_prev,  n_prev;
    logic                               r_s2_span,  n_s2_span;
    logic                               r_s2_dypos, n_s2_dypos;
    logic signed [DW-1:0]               r_s2_dxp, n_s2_dxp;
    logic signed [DW-1:0]               r_s2_dy,  n_s2_dy;
    logic signed [DW-1:0]               r_s2_dxe, n_s2_dxe;
    logic signed [DW-1:0]               r_s2_dyp, n_s2_dyp;
    logic                               r_s3_span,  n_s3_span;
    logic                               r_s3_dypos, n_s3_dypos;
    logic signed [PW-1:0]               r_s3_lhs, n_s3_lhs;
    logic signed [PW-1:0]               r_s3_rhs, n_s3_rhs;

    logic signed [DW-1:0] xi, yi, xj, yj, px, py;
    logic [lpc_pkg::CNT_W-1:0] rd_idx;
    logic                      left;
    logic                      done;

    always_comb begin
        xi = DW'($signed(i_rd_data[lpc_pkg::COORD_W-1:0]));
        yi = DW'($signed(i_rd_data[lpc_pkg::VERT_W-1:lpc_pkg::COORD_W]));
        xj = DW'($signed(r_prev[lpc_pkg::COORD_W-1:0]));
        yj = DW'($signed(r_prev[lpc_pkg::VERT_W-1:lpc_pkg::COORD_W]));
        px = DW'(r_px);
        py = DW'(r_py);
        left = r_s3_dypos ? (r_s3_lhs < r_s3_rhs) : (r_s3_lhs > r_s3_rhs);
        done = r_busy && !r_issuing && !r_rd_vld && !r_s2_vld && !r_s3_vld;

        // The first read fetches the last vertex so that edge 0 closes the ring.
        if (r_idx == '0) begin
            rd_idx = r_count - lpc_pkg::CNT_W'(1);
        end else begin
            rd_idx = r_idx - lpc_pkg::CNT_W'(1);
        end

        n_busy     = r_busy;
        n_issuing  = r_issuing;
        n_idx      = r_idx;
        n_first    = r_first;
        n_odd      = r_odd;
        n_count    = r_count;
        n_px       = r_px;
        n_py       = r_py;
        n_prev     = r_prev;
        n_rd_vld   = r_issuing;
        n_s2_vld   = 1'b0;
        n_s3_vld   = r_s2_vld;
        n_s2_span  = r_s2_span;
        n_s2_dypos = r_s2_dypos;
        n_s2_dxp   = r_s2_dxp;
        n_s2_dy    = r_s2_dy;
        n_s2_dxe   = r_s2_dxe;
        n_s2_dyp   = r_s2_dyp;

        // Issue reads.
        if (r_issuing) begin
            n_idx = r_idx + lpc_pkg::CNT_W'(1);
            if (r_idx == r_count) begin
                n_issuing = 1'b0;
            end
        end

        // Stage 1: edge differences.
        if (r_rd_vld) begin
            n_prev  = i_rd_data;
            n_first = 1'b0;
            if (!r_first) begin
                n_s2_vld   = 1'b1;
                n_s2_span  = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));
                n_s2_dypos = yj > yi;
                n_s2_dxp   = px - xi;
                n_s2_dy    = yj - yi;
                n_s2_dxe   = xj - xi;
                n_s2_dyp   = py - yi;
            end
        end

        // Stage 2: cross products.
        n_s3_span  = r_s2_span;
        n_s3_dypos = r_s2_dypos;
        n_s3_lhs   = r_s2_dxp * r_s2_dy;
        n_s3_rhs   = r_s2_dxe * r_s2_dyp;

        // Stage 3: parity.
        if (r_s3_vld && r_s3_span && left) begin
            n_odd = !r_odd;
        end

        if (done) begin
            n_busy = 1'b0;
        end

        if (i_req.start) begin
            n_busy    = 1'b1;
            n_issuing = 1'b1;
            n_idx     = '0;
            n_first   = 1'b1;
            n_odd     = 1'b0;
            n_count   = i_req.count;
            n_px      = i_req.px;
            n_py      = i_req.py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_first   <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_odd     <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_issuing <= n_issuing;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_first   <= n_first;
            r_s2_vld  <= n_s2_vld;
            r_s3_vld  <= n_s3_vld;
            r_odd     <= n_odd;
        end
        r_count    <= n_count;
        r_px       <= n_px;
        r_py       <= n_py;
        r_prev     <= n_prev;
        r_s2_span  <= n_s2_span;
        r_s2_dypos <= n_s2_dypos;
        r_s2_dxp   <= n_s2_dxp;
        r_s2_dy    <= n_s2_dy;
        r_s2_dxe   <= n_s2_dxe;
        r_s2_dyp   <= n_s2_dyp;
        r_s3_span  <= n_s3_span;
        r_s3_dypos <= n_s3_dypos;
        r_s3_lhs   <= n_s3_lhs;
        r_s3_rhs   <= n_s3_rhs;
    end

    assign o_rsp.done = done;
    assign o_rsp.odd  = r_odd;
    assign o_rd.en    = r_issuing;
    assign o_rd.addr  = rd_idx[lpc_pkg::ADDR_W-1:0];

endmodule

// ===== tb/lasso_polygon_containment_top_tb.sv =====
// ----------------------------------------------------------------------------
// lasso_polygon_containment_top_tb: self-checking bench for the lasso block
// Drives clear, append, point and box items through the valid/stall input
// channel and checks every result against an even-odd crossing predictor
// that keeps its own copy of the polygon. A directed table comes first, then
// random polygon sessions under three idling mixes, then a full-store pass.
// ----------------------------------------------------------------------------
module lasso_polygon_containment_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int SHOW_LIMIT = 10;
    localparam int CMIN = -32768;
    localparam int CMAX = 32767;

    // One result item as the block reports it.
    typedef struct packed {
        logic in_poly;
        logic status;
    } t_answer;

    // One row of the directed table. Where known is set, the row carries its
    // own expected answer; otherwise the predictor supplies it.
    typedef struct packed {
        lpc_pkg::t_cmd cmd;
        int   xl;
        int   yl;
        int   xh;
        int   yh;
        logic known;
        logic in_poly;
        logic status;
    } t_vector_row;

    localparam int DIR_ROWS = 23;
    localparam t_vector_row DIRECTED [DIR_ROWS] = '{
        // Empty store: every test is outside.
        '{lpc_pkg::CMD_POINT,  0,    0,    0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_BOX,    -5,   -5,   5,    5,    1'b1, 1'b0, 1'b0},
        // Build the largest square the coordinates allow, corner by corner.
        '{lpc_pkg::CMD_APPEND, CMIN, CMIN, 0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_APPEND, CMAX, CMIN, CMAX, CMAX, 1'b1, 1'b0, 1'b0},
        // Two vertices are still not a polygon.
        '{lpc_pkg::CMD_POINT,  0,    0,    0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_APPEND, CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_APPEND, CMIN, CMAX, 0,    0,    1'b1, 1'b0, 1'b0},
        // Center, both extreme corners and the left edge.
        '{lpc_pkg::CMD_POINT,  0,    0,    CMAX, CMIN, 1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  CMIN, CMIN, 0,    0,    1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  CMAX, CMAX, 0,    0,    1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  CMIN, 0,    0,    0,    1'b0, 1'b0, 1'b0},
        // Plain box, reversed box and a box on the full extent.
        '{lpc_pkg::CMD_BOX,    -100, -100, 100,  100,  1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_BOX,    100,  100,  -100, -100, 1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_BOX,    CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_CLEAR,  CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  0,    0,    0,    0,    1'b1, 1'b0, 1'b0},
        // Right triangle with a horizontal bottom edge.
        '{lpc_pkg::CMD_APPEND, 0,    0,    0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_APPEND, 100,  0,    0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_APPEND, 0,    100,  0,    0,    1'b1, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  50,   0,    0,    0,    1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_POINT,  10,   10,   0,    0,    1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_BOX,    1,    1,    20,   20,   1'b0, 1'b0, 1'b0},
        '{lpc_pkg::CMD_CLEAR,  0,    0,    0,    0,    1'b1, 1'b0, 1'b0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_command = 2'd0;
    logic signed [15:0] i_x_low = 16'sd0;
    logic signed [15:0] i_y_low = 16'sd0;
    logic signed [15:0] i_x_high = 16'sd0;
    logic signed [15:0] i_y_high = 16'sd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_inside_res;
    logic               o_status;

    // The bench's own copy of the polygon.
    int vert_x [lpc_pkg::MAX_VERTS];
    int vert_y [lpc_pkg::MAX_VERTS];
    int vert_count = 0;

    t_answer pending_answers [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int n_points = 0;
    int n_boxes = 0;
    int n_dropped = 0;

    lasso_polygon_containment_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_x_low      (i_x_low),
        .i_y_low      (i_y_low),
        .i_x_high     (i_x_high),
        .i_y_high     (i_y_high),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inside_res (o_inside_res),
        .o_status     (o_status)
    );

    always begin
        #HALF_PERIOD;
        i_clk = ~i_clk;
    end

    // Even-odd crossing test of one point against the stored polygon. An
    // edge counts when the query y lies in [low end, high end) and the point
    // is strictly left of the edge; the compare is cross-multiplied, with the
    // sense flipped for edges that run downward.
    function automatic bit lasso_holds(int px, int py);
        bit     odd;
        int     j, xi, yi, xj, yj;
        longint dy, lhs, rhs;
        odd = 1'b0;
        if (vert_count < 3) begin
            return 1'b0;
        end
        j = vert_count - 1;
        for (int i = 0; i < vert_count; i++) begin
            xi = vert_x[i];
            yi = vert_y[i];
            xj = vert_x[j];
            yj = vert_y[j];
            if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
                dy  = longint'(yj) - longint'(yi);
                lhs = (longint'(px) - longint'(xi)) * dy;
                rhs = (longint'(xj) - longint'(xi)) * (longint'(py) - longint'(yi));
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) begin
                    odd = ~odd;
                end
            end
            j = i;
        end
        return odd;
    endfunction

    // Applies one item to the polygon copy and returns the answer it earns.
    function automatic t_answer lasso_answer(lpc_pkg::t_cmd cmd, int xl, int yl,
                                             int xh, int yh);
        t_answer ans;
        ans = '{in_poly: 1'b0, status: 1'b0};
        case (cmd)
            lpc_pkg::CMD_CLEAR: begin
                vert_count = 0;
            end
            lpc_pkg::CMD_APPEND: begin
                if (vert_count < lpc_pkg::MAX_VERTS) begin
                    vert_x[vert_count] = xl;
                    vert_y[vert_count] = yl;
                    vert_count++;
                end else begin
                    ans.status = 1'b1;
                end
            end
            lpc_pkg::CMD_POINT: begin
                ans.in_poly = lasso_holds(xl, yl);
            end
            default: begin
                ans.in_poly = lasso_holds(xl, yl) && lasso_holds(xl, yh) &&
                              lasso_holds(xh, yh) && lasso_holds(xh, yl);
            end
        endcase
        return ans;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Offers one item, idling first at the current sender rate, and waits for
    // the block to take it. The expected answer is queued at acceptance. The
    // valid line is left high on return so that back-to-back items never see
    // it dropped and raised within one step.
    task automatic offer_item(input lpc_pkg::t_cmd cmd, input int xl, input int yl,
                              input int xh, input int yh, input logic known = 1'b0,
                              input logic k_in_poly = 1'b0, input logic k_status = 1'b0);
        t_answer ans;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_x_low   <= 16'(xl);
        i_y_low   <= 16'(yl);
        i_x_high  <= 16'(xh);
        i_y_high  <= 16'(yh);
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        ans = lasso_answer(cmd, xl, yl, xh, yh);
        if (known) begin
            ans = '{in_poly: k_in_poly, status: k_status};
        end
        pending_answers.insert(pending_answers.size(), ans);
        items_sent++;
        if (cmd == lpc_pkg::CMD_POINT) n_points++;
        if (cmd == lpc_pkg::CMD_BOX) n_boxes++;
        if (ans.status) n_dropped++;
    endtask

    // The sender stops and waits until every queued answer has come back.
    task automatic wait_all_answered();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_answers.size() != 0);
    endtask

    // Scale 0 keeps coordinates tiny so that tests land on vertices and
    // edges; scale 1 is a typical screen; scale 2 spans the full range.
    function automatic int rand_coord(int scale);
        case (scale)
            0:       return int'($urandom_range(0, 31)) - 16;
            1:       return int'($urandom_range(0, 4095)) - 2048;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Random polygon sessions: mostly a clear, a fresh polygon and a few
    // tests against it, with some raw items of any command mixed in.
    task automatic random_sessions(int quota);
        int         stop_at, scale, k, tests, pick, vi, xl, yl;
        logic [1:0] raw_cmd;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 82) begin
                pick  = $urandom_range(0, 99);
                scale = (pick < 45) ? 0 : (pick < 85) ? 1 : 2;
                offer_item(lpc_pkg::CMD_CLEAR, rand_coord(2), rand_coord(2),
                           rand_coord(2), rand_coord(2));
                pick = $urandom_range(0, 99);
                k = (pick < 10) ? $urandom_range(0, 2) :
                    (pick < 92) ? $urandom_range(3, 10) : $urandom_range(11, 40);
                repeat (k) begin
                    offer_item(lpc_pkg::CMD_APPEND, rand_coord(scale), rand_coord(scale),
                               rand_coord(2), rand_coord(2));
                end
                tests = $urandom_range(1, 6);
                repeat (tests) begin
                    xl = rand_coord(scale);
                    yl = rand_coord(scale);
                    // Sometimes aim straight at a stored vertex or its row.
                    if (vert_count > 0 && $urandom_range(0, 99) < 25) begin
                        vi = $urandom_range(0, vert_count - 1);
                        yl = vert_y[vi];
                        if ($urandom_range(0, 1) == 1) xl = vert_x[vi];
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        offer_item(lpc_pkg::CMD_POINT, xl, yl, rand_coord(2),
                                   rand_coord(2));
                    end else if (scale < 2 && $urandom_range(0, 99) < 30) begin
                        offer_item(lpc_pkg::CMD_BOX, xl, yl,
                                   xl + int'($urandom_range(0, 8)),
                                   yl + int'($urandom_range(0, 8)));
                    end else begin
                        offer_item(lpc_pkg::CMD_BOX, xl, yl, rand_coord(scale),
                                   rand_coord(scale));
                    end
                end
            end else begin
                raw_cmd = 2'($urandom_range(0, 3));
                offer_item(lpc_pkg::t_cmd'(raw_cmd), rand_coord(2), rand_coord(2),
                           rand_coord(2), rand_coord(2));
            end
        end
    endtask

    // Fills the store to the last entry, pushes a few more vertices that
    // must be dropped, then runs tests over the largest polygon.
    task automatic fill_store();
        offer_item(lpc_pkg::CMD_CLEAR, 0, 0, 0, 0);
        while (vert_count < lpc_pkg::MAX_VERTS) begin
            offer_item(lpc_pkg::CMD_APPEND, int'($urandom_range(0, 600)) - 300,
                       int'($urandom_range(0, 600)) - 300, 0, 0);
        end
        repeat (3) begin
            offer_item(lpc_pkg::CMD_APPEND, rand_coord(2), rand_coord(2), rand_coord(2),
                       rand_coord(2));
        end
        offer_item(lpc_pkg::CMD_POINT, 0, 0, 0, 0);
        offer_item(lpc_pkg::CMD_POINT, rand_coord(0), rand_coord(0), 0, 0);
        offer_item(lpc_pkg::CMD_BOX, -20, -20, 20, 20);
        offer_item(lpc_pkg::CMD_CLEAR, 0, 0, 0, 0);
    endtask

    // Result side: checks every taken result against the oldest expectation
    // and drives the result stall, including the long hold-offs on request.
    always @(posedge i_clk) begin : result_side
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                flag_mismatch($sformatf("result (in_poly=%0b status=%0b) with none pending",
                                        o_inside_res, o_status));
            end else begin
                want = pending_answers.pop_front();
                if (o_inside_res !== want.in_poly) begin
                    flag_mismatch($sformatf("in_poly expected %0b, got %0b",
                                            want.in_poly, o_inside_res));
                end
                if (o_status !== want.status) begin
                    flag_mismatch($sformatf("status expected %0b, got %0b",
                                            want.status, o_status));
                end
            end
        end
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            i_stall     <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial begin
        int guard;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles often, receiver stalls most of the time.
        tx_idle_pct = 38;
        rx_idle_pct = 80;
        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_item(DIRECTED[r].cmd, DIRECTED[r].xl, DIRECTED[r].yl, DIRECTED[r].xh,
                       DIRECTED[r].yh, DIRECTED[r].known, DIRECTED[r].in_poly,
                       DIRECTED[r].status);
        end
        random_sessions(150);

        // The receiver holds off for a long stretch while items keep coming,
        // so the result register fills and the input backs up.
        hold_asked <= hold_asked + 1;
        random_sessions(40);
        wait_all_answered();

        // Swap the idling rates.
        tx_idle_pct = 80;
        rx_idle_pct = 38;
        random_sessions(200);
        wait_all_answered();

        // Full throughput on both sides, including the full-store pass.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_sessions(180);
        fill_store();

        i_valid <= 1'b0;
        guard = 0;
        while (pending_answers.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        // Waiting on after the queue drains catches any result that should not be there.
        repeat (32) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0d expected results never arrived", pending_answers.size());
            mismatches += pending_answers.size();
        end

        $display("Covered %0d items: %0d point tests, %0d box tests,",
                 items_sent, n_points, n_boxes);
        $display("%0d vertices dropped on a full store, %0d results checked, %0d mismatches.",
                 n_dropped, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
